// ----- rtl/bcdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, register indices and BCD helpers for the calendar clock
// register file.
// ----------------------------------------------------------------------------
package bcdc_pkg;

	// Operation carried in tuser
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// One bus transaction as seen by the register file
	typedef struct packed {
		func_t       func;
		logic [3:0]  idx;
		logic [7:0]  data;
	} op_t;

	// Register indices
	localparam logic [3:0] REG_SEC   = 4'd0;
	localparam logic [3:0] REG_MIN   = 4'd2;
	localparam logic [3:0] REG_HOUR  = 4'd4;
	localparam logic [3:0] REG_DOW   = 4'd6;
	localparam logic [3:0] REG_DOM   = 4'd7;
	localparam logic [3:0] REG_MONTH = 4'd8;
	localparam logic [3:0] REG_YEAR  = 4'd9;
	localparam logic [3:0] REG_B_IDX = 4'd11;
	localparam logic [3:0] REG_D_IDX = 4'd13;

	// Clock registers 0..9 are writable and stored
	localparam int unsigned NUM_CLK_REGS = 10;
	localparam logic [3:0]  CLK_REG_LIMIT = 4'd10;

	localparam logic [7:0] REG_B_RESET = 8'h02;
	localparam logic [7:0] REG_D_VALUE = 8'h80;
	localparam int unsigned MODE_BIN_BIT = 2;

	// Days in the given month; invalid months count as 31, leap Feb on year[1:0]==0
	function automatic logic [7:0] days_in_month(input logic [7:0] month,
	                                             input logic [7:0] year);
		logic [7:0] d;
		begin
			unique case (month)
				8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 8'd31;
				8'd4, 8'd6, 8'd9, 8'd11:                   d = 8'd30;
				8'd2: d = (year[1:0] == 2'b00) ? 8'd29 : 8'd28;
				default:                                  d = 8'd31;
			endcase
			return d;
		end
	endfunction

	// Binary to BCD: tens via multiply by 205 >> 11 (exact below 1029)
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [17:0] prod;
		logic [7:0]  tens;
		logic [7:0]  units;
		begin
			prod  = {10'd0, v} * 18'd205;
			tens  = prod[18-1:11] & 8'h7F;
			units = v - 8'(tens * 8'd10);
			return 8'({tens[3:0], 4'b0000}) + units;
		end
	endfunction

	// BCD to binary; nibbles above 9 are taken as they stand
	function automatic logic [7:0] from_bcd(input logic [7:0] v);
		begin
			return 8'(v[7:4] * 8'd10) + {4'b0000, v[3:0]};
		end
	endfunction

endpackage

// ----- rtl/bcdc_regs.sv -----
// ----------------------------------------------------------------------------
// bcdc_regs
// Clock register store with the one-second calendar update, BCD write
// conversion and the read mux.
// ----------------------------------------------------------------------------
module bcdc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,       // apply op this cycle
	input  bcdc_pkg::op_t      op,
	input  logic [7:0]         reg_b,
	output logic [7:0]         rd_data
);

	logic [7:0] regs_q [bcdc_pkg::NUM_CLK_REGS];
	logic [7:0] regs_d [bcdc_pkg::NUM_CLK_REGS];
	logic       bin_mode;
	logic [7:0] sec_inc, min_inc, hour_inc, dow_inc, dom_inc, month_inc, year_inc;
	logic [7:0] dim;
	logic [7:0] rd_raw;

	assign bin_mode = reg_b[bcdc_pkg::MODE_BIN_BIT];

	// Incremented values, wrap at 256
	assign sec_inc   = regs_q[bcdc_pkg::REG_SEC]   + 8'd1;
	assign min_inc   = regs_q[bcdc_pkg::REG_MIN]   + 8'd1;
	assign hour_inc  = regs_q[bcdc_pkg::REG_HOUR]  + 8'd1;
	assign dow_inc   = regs_q[bcdc_pkg::REG_DOW]   + 8'd1;
	assign dom_inc   = regs_q[bcdc_pkg::REG_DOM]   + 8'd1;
	assign month_inc = regs_q[bcdc_pkg::REG_MONTH] + 8'd1;
	assign year_inc  = regs_q[bcdc_pkg::REG_YEAR]  + 8'd1;
	assign dim = bcdc_pkg::days_in_month(regs_q[bcdc_pkg::REG_MONTH],
	                                     regs_q[bcdc_pkg::REG_YEAR]);

	// Next state: tick carry chain or bus write
	always_comb begin
		regs_d = regs_q;
		unique case (op.func)
			bcdc_pkg::FUNC_TICK: begin
				if (sec_inc < 8'd60) begin
					regs_d[bcdc_pkg::REG_SEC] = sec_inc;
				end else begin
					regs_d[bcdc_pkg::REG_SEC] = 8'd0;
					if (min_inc < 8'd60) begin
						regs_d[bcdc_pkg::REG_MIN] = min_inc;
					end else begin
						regs_d[bcdc_pkg::REG_MIN] = 8'd0;
						if (hour_inc < 8'd24) begin
							regs_d[bcdc_pkg::REG_HOUR] = hour_inc;
						end else begin
							regs_d[bcdc_pkg::REG_HOUR] = 8'd0;
							regs_d[bcdc_pkg::REG_DOW] = (dow_inc > 8'd7) ? 8'd1 : dow_inc;
							if (dom_inc <= dim) begin
								regs_d[bcdc_pkg::REG_DOM] = dom_inc;
							end else begin
								regs_d[bcdc_pkg::REG_DOM] = 8'd1;
								if (month_inc <= 8'd12) begin
									regs_d[bcdc_pkg::REG_MONTH] = month_inc;
								end else begin
									regs_d[bcdc_pkg::REG_MONTH] = 8'd1;
									regs_d[bcdc_pkg::REG_YEAR] =
										(year_inc >= 8'd100) ? 8'd0 : year_inc;
								end
							end
						end
					end
				end
			end
			bcdc_pkg::FUNC_WRITE: begin
				if (op.idx < bcdc_pkg::CLK_REG_LIMIT) begin
					regs_d[op.idx] = bin_mode ? op.data : bcdc_pkg::from_bcd(op.data);
				end
			end
			default: begin
			end
		endcase
	end

	// Store, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcdc_pkg::NUM_CLK_REGS; i++) begin
				regs_q[i] <= 8'd0;
			end
		end else if (en) begin
			regs_q <= regs_d;
		end
	end

	// Read mux; fixed registers outside the store
	always_comb begin
		rd_raw  = 8'd0;
		rd_data = 8'd0;
		if (op.func == bcdc_pkg::FUNC_READ) begin
			if (op.idx < bcdc_pkg::CLK_REG_LIMIT) begin
				rd_raw  = regs_q[op.idx];
				rd_data = bin_mode ? rd_raw : bcdc_pkg::to_bcd(rd_raw);
			end else if (op.idx == bcdc_pkg::REG_B_IDX) begin
				rd_data = reg_b;
			end else if (op.idx == bcdc_pkg::REG_D_IDX) begin
				rd_data = bcdc_pkg::REG_D_VALUE;
			end
		end
	end

endmodule

// ----- rtl/bcd_calendar_clock_registers.sv -----
// ----------------------------------------------------------------------------
// bcd_calendar_clock_registers
// Sixteen-byte calendar clock register file with a one-second tick.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, for every operation (tick, read,
// write, and the unused code, which answers zero). A new transaction can be
// taken every cycle while the output side does not stall; each accepted
// transaction waits in the input stage, where the register store is updated
// and the read mux evaluated, then moves into the result register, which
// holds the answer while the output side stalls. Register B is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce. Clock registers live in
// binary; reads and writes of indices 0..9 go through BCD unless register B bit 2 is set.
module bcd_calendar_clock_registers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] reg_index, [11:4] write_data, [15:12] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [7:0] read_data
);

	logic          valid_s1;
	bcdc_pkg::op_t op_s1;
	logic          s1_move;
	logic [7:0]    rd_data;
	logic [7:0]    reg_b_q;
	logic          m_valid_q;
	logic [7:0]    m_data_q;

	// Register B
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_b_q <= bcdc_pkg::REG_B_RESET;
		end else if (cfg_wr_en) begin
			reg_b_q <= cfg_wr_data;
		end
	end

	// Input stage handshake
	assign s1_move       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1.func <= bcdc_pkg::func_t'(s_axis_tuser);
			op_s1.idx  <= s_axis_tdata[3:0];
			op_s1.data <= s_axis_tdata[11:4];
		end
	end

	// Register store and datapath
	bcdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (s1_move),
		.op      (op_s1),
		.reg_b   (reg_b_q),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_move) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_data_q <= rd_data;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// A stage that cannot drain keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> valid_s1)
		else $error("input stage dropped a transaction");

	// An empty input stage always takes a transaction
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// Every drained transaction shows up as a result
	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> m_axis_tvalid)
		else $error("result missing after stage drain");

	// Only reads return data
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && op_s1.func != bcdc_pkg::FUNC_READ) |=> (m_axis_tdata == 8'd0))
		else $error("non-read transaction returned data");

endmodule
